// ===== sv/masked_kruskal_spanning_tree_assert.svh =====
// Assertion macros used by the checker file
`ifndef MASKED_KRUSKAL_SPANNING_TREE_ASSERT_SVH
`define MASKED_KRUSKAL_SPANNING_TREE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define MKST_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication outside reset
`define MKST_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== sv/mkst_pkg.sv =====
// Package: constants, payload types and sequencer states
`default_nettype none
package mkst_pkg;
  localparam int MaxEdges    = 128;
  localparam int MaxVertices = 16;
  localparam int EIdxW = $clog2(MaxEdges);
  localparam int ECntW = $clog2(MaxEdges + 1);
  localparam int VIdxW = $clog2(MaxVertices);
  localparam int InfResetVal = 1000000;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_APPEND  = 2'd1,
    FUNC_COMPUTE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  edge_from;
    logic [3:0]  edge_to;
    logic [15:0] edge_weight;
    logic [15:0] vertex_mask;
    logic [4:0]  need_count;
  } in_req_t;

  typedef struct packed {
    logic [23:0] tree_cost;
    logic        spanning;
  } out_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEL_RD,   // read weight/endpoints of candidate edge
    ST_SEL_CMP,  // compare candidate against current best
    ST_PICK_RD,  // read chosen edge
    ST_PICK_EV,  // mask test, start root finds
    ST_FIND_A,
    ST_FIND_B,
    ST_UNION,
    ST_DONE
  } state_t;
endpackage
`default_nettype wire

// ===== sv/mkst_ram.sv =====
// Generic single-port-write, one-read RAM with registered read
`default_nettype none
module mkst_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== sv/masked_kruskal_spanning_tree.sv =====
// Top level: edge list storage and Kruskal sequencer
// Clear and append requests never raise busy. A compute request selects
// edges in ascending weight order (ties by append order) by a selection
// scan over the edge memory through one comparator. For each of the N stored
// edges the block runs one full scan that reads and then compares every
// stored edge (ST_SEL_RD, ST_SEL_CMP). It then reads, tests and retires the
// chosen edge (ST_PICK_RD, ST_PICK_EV, ST_UNION). When both ends are in the
// mask, it adds a root search over the 16-entry parent table, one parent
// step at a time, first for one end (ST_FIND_A) and then for the other
// (ST_FIND_B). A last state, ST_DONE, forms the result. The result strobe
// out_valid is high for exactly one cycle, in the first cycle in which busy
// is low; the receiver cannot stall it. A new request may be accepted in
// that same cycle. No clearing pass is needed.
`default_nettype none
module masked_kruskal_spanning_tree import mkst_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output      logic     busy,
  input  wire in_req_t  in_req,
  output      logic     out_valid,
  output      out_res_t out_res,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_wdata
);
  state_t state_r, state_nxt;
  logic [23:0] inf_cost_r;
  logic [ECntW-1:0] cnt_r, cnt_nxt;
  // Selection: (w,idx) of last taken edge, best of current scan
  logic [15:0] last_w_r, last_w_nxt, best_w_r, best_w_nxt;
  logic [EIdxW-1:0] last_i_r, last_i_nxt, best_i_r, best_i_nxt;
  logic first_r, first_nxt, found_r, found_nxt;
  logic [ECntW-1:0] scan_r, scan_nxt, taken_r, taken_nxt;
  logic [15:0] mask_r, mask_nxt;
  logic [4:0] need_r, need_nxt;
  logic [23:0] cost_r, cost_nxt;
  logic [4:0] joined_r, joined_nxt;
  logic [VIdxW-1:0] parent_r [MaxVertices];
  logic [VIdxW-1:0] va_r, va_nxt, vb_r, vb_nxt, ra_r, ra_nxt;
  logic links_rst, link_we;
  logic [VIdxW-1:0] link_idx, link_val;
  out_res_t res_nxt;
  logic res_v_nxt;

  // Edge memories
  logic ram_we;
  logic [EIdxW-1:0] ram_raddr;
  logic [3:0] rd_from, rd_to;
  logic [15:0] rd_w;
  logic [EIdxW-1:0] rd_idx_r;

  assign ram_we = start && !busy && (in_req.func == FUNC_APPEND) && (cnt_r < ECntW'(MaxEdges));

  mkst_ram #(.Width(4), .Depth(MaxEdges)) u_from (
    .clk, .we(ram_we), .waddr(cnt_r[EIdxW-1:0]), .wdata(in_req.edge_from),
    .raddr(ram_raddr), .rdata(rd_from));
  mkst_ram #(.Width(4), .Depth(MaxEdges)) u_to (
    .clk, .we(ram_we), .waddr(cnt_r[EIdxW-1:0]), .wdata(in_req.edge_to),
    .raddr(ram_raddr), .rdata(rd_to));
  mkst_ram #(.Width(16), .Depth(MaxEdges)) u_wt (
    .clk, .we(ram_we), .waddr(cnt_r[EIdxW-1:0]), .wdata(in_req.edge_weight),
    .raddr(ram_raddr), .rdata(rd_w));

  assign busy = (state_r != ST_IDLE);
  assign ram_raddr = (state_r == ST_PICK_RD) ? best_i_r : scan_r[EIdxW-1:0];

  // Candidate is after last taken edge in (weight, index) order
  logic after_last, better;
  assign after_last = first_r || (rd_w > last_w_r) || ((rd_w == last_w_r) && (rd_idx_r > last_i_r));
  assign better = !found_r || (rd_w < best_w_r);

  // Parent lookups for root search (one step per cycle)
  logic [VIdxW-1:0] pa, pb;
  assign pa = parent_r[va_r];
  assign pb = parent_r[vb_r];

  logic a_in, b_in;
  assign a_in = mask_r[rd_from];
  assign b_in = mask_r[rd_to];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    last_w_nxt = last_w_r; last_i_nxt = last_i_r;
    best_w_nxt = best_w_r; best_i_nxt = best_i_r;
    first_nxt = first_r; found_nxt = found_r;
    scan_nxt = scan_r; taken_nxt = taken_r;
    mask_nxt = mask_r; need_nxt = need_r;
    cost_nxt = cost_r; joined_nxt = joined_r;
    va_nxt = va_r; vb_nxt = vb_r; ra_nxt = ra_r;
    links_rst = 1'b0; link_we = 1'b0; link_idx = '0; link_val = '0;
    res_v_nxt = 1'b0;
    res_nxt = out_res;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (func_t'(in_req.func))
            FUNC_CLEAR: cnt_nxt = '0;
            FUNC_APPEND: if (cnt_r < ECntW'(MaxEdges)) cnt_nxt = cnt_r + 1'b1;
            FUNC_COMPUTE: begin
              mask_nxt = in_req.vertex_mask;
              need_nxt = in_req.need_count;
              cost_nxt = '0;
              joined_nxt = 5'd1;
              links_rst = 1'b1;
              first_nxt = 1'b1;
              taken_nxt = '0;
              scan_nxt = '0;
              found_nxt = 1'b0;
              state_nxt = (cnt_r == '0) ? ST_DONE : ST_SEL_RD;
            end
            FUNC_NONE: ;
          endcase
        end
      end
      ST_SEL_RD: state_nxt = ST_SEL_CMP;
      ST_SEL_CMP: begin
        if (after_last && better) begin
          found_nxt = 1'b1; best_w_nxt = rd_w; best_i_nxt = rd_idx_r;
        end
        if (scan_r + 1'b1 == cnt_r) state_nxt = ST_PICK_RD;
        else begin
          scan_nxt = scan_r + 1'b1; state_nxt = ST_SEL_RD;
        end
      end
      ST_PICK_RD: state_nxt = ST_PICK_EV;
      ST_PICK_EV: begin
        first_nxt = 1'b0;
        last_w_nxt = best_w_r; last_i_nxt = best_i_r;
        va_nxt = rd_from[VIdxW-1:0]; vb_nxt = rd_to[VIdxW-1:0];
        state_nxt = (a_in && b_in) ? ST_FIND_A : ST_UNION;
        if (!(a_in && b_in)) ra_nxt = '1;
      end
      ST_FIND_A: begin
        if (pa == va_r) begin
          ra_nxt = va_r; state_nxt = ST_FIND_B;
        end else va_nxt = pa;
      end
      ST_FIND_B: begin
        if (pb == vb_r) begin
          state_nxt = ST_UNION;
          if (ra_r != vb_r) begin
            link_we = 1'b1; link_idx = ra_r; link_val = vb_r;
            cost_nxt = cost_r + {8'd0, best_w_r};
            joined_nxt = joined_r + 1'b1;
          end
        end else vb_nxt = pb;
      end
      ST_UNION: begin
        taken_nxt = taken_r + 1'b1;
        scan_nxt = '0; found_nxt = 1'b0;
        state_nxt = (taken_r + 1'b1 == cnt_r) ? ST_DONE : ST_SEL_RD;
      end
      ST_DONE: begin
        res_v_nxt = 1'b1;
        if (joined_r < need_r) begin
          res_nxt.tree_cost = inf_cost_r; res_nxt.spanning = 1'b0;
        end else begin
          res_nxt.tree_cost = cost_r; res_nxt.spanning = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      inf_cost_r <= 24'(InfResetVal);
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_we) inf_cost_r <= cfg_wdata;
      out_valid <= res_v_nxt;
    end
  end

  // Parent table: reset to identity per compute, one link per union
  always_ff @(posedge clk) begin
    for (int k = 0; k < MaxVertices; k++) begin
      if (!rst_n || links_rst) parent_r[k] <= VIdxW'(k);
      else if (link_we && link_idx == VIdxW'(k)) parent_r[k] <= link_val;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= scan_r[EIdxW-1:0];
    last_w_r <= last_w_nxt; last_i_r <= last_i_nxt;
    best_w_r <= best_w_nxt; best_i_r <= best_i_nxt;
    first_r <= first_nxt; found_r <= found_nxt;
    scan_r <= scan_nxt; taken_r <= taken_nxt;
    mask_r <= mask_nxt; need_r <= need_nxt;
    cost_r <= cost_nxt; joined_r <= joined_nxt;
    va_r <= va_nxt; vb_r <= vb_nxt; ra_r <= ra_nxt;
    out_res <= res_nxt;
  end
endmodule
`default_nettype wire

// ===== sv/mkst_checker.sv =====
// Port-level checker for the spanning tree block, bound to the top level
`default_nettype none
`include "masked_kruskal_spanning_tree_assert.svh"
module mkst_checker import mkst_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire in_req_t  in_req,
  input wire logic     out_valid
);
  // Compute request makes the block busy next cycle
  `MKST_ASSERT_NXT(a_cmp_busy, start && !busy && in_req.func == FUNC_COMPUTE, busy)
  // Clear/append never raise busy
  `MKST_ASSERT_NXT(a_ld_idle, start && !busy && in_req.func != FUNC_COMPUTE, !busy)
  // Result strobe is a single pulse
  `MKST_ASSERT_NXT(a_pulse, out_valid, !out_valid)
  // Result appears only once the block went idle
  `MKST_ASSERT_IMP(a_res_idle, out_valid, !busy && $past(busy))
endmodule

bind masked_kruskal_spanning_tree mkst_checker u_mkst_checker (
  .clk, .rst_n, .start, .busy, .in_req, .out_valid);
`default_nettype wire

// ===== tb/masked_kruskal_spanning_tree_tb.sv =====
// Testbench for the masked Kruskal spanning-tree block: directed table, then random requests
`default_nettype none
module masked_kruskal_spanning_tree_tb;
  import mkst_pkg::*;

  localparam int HoldOff = 20;
  localparam int MaxCycles = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_req_t in_req = '0;
  logic out_valid;
  out_res_t out_res;
  logic cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;

  masked_kruskal_spanning_tree u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [23:0] inf_cost;
  logic [3:0]  efrom [MaxEdges];
  logic [3:0]  eto   [MaxEdges];
  logic [15:0] ewt   [MaxEdges];
  int          ecount;
  out_res_t    cost_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          sender_idle = 0;

  task automatic report(input string what, input out_res_t got, input out_res_t want);
    $display("error %s: got cost %0d span %0b, want cost %0d span %0b",
             what, got.tree_cost, got.spanning, want.tree_cost, want.spanning);
    errors++;
  endtask

  // Kruskal over the stored edges, stable by weight then append order
  function automatic out_res_t tree_cost_of(input in_req_t r);
    int order[MaxEdges];
    int par[MaxVertices];
    int i, j, e, ra, rb, joined;
    logic [23:0] sum;
    out_res_t res;
    for (i = 0; i < ecount; i++) begin
      e = i;
      j = i;
      while (j > 0 && ewt[order[j-1]] > ewt[e]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = e;
    end
    for (i = 0; i < MaxVertices; i++) par[i] = i;
    sum = '0;
    joined = 1;
    for (i = 0; i < ecount; i++) begin
      e = order[i];
      if (r.vertex_mask[efrom[e]] && r.vertex_mask[eto[e]]) begin
        ra = efrom[e];
        while (par[ra] != ra) ra = par[ra];
        rb = eto[e];
        while (par[rb] != rb) rb = par[rb];
        if (ra != rb) begin
          sum = sum + ewt[e];
          par[ra] = rb;
          joined++;
        end
      end
    end
    if (joined < r.need_count) begin
      res.tree_cost = inf_cost;
      res.spanning = 1'b0;
    end else begin
      res.tree_cost = sum;
      res.spanning = 1'b1;
    end
    return res;
  endfunction

  function automatic void predict(input in_req_t r);
    case (r.func)
      FUNC_CLEAR: ecount = 0;
      FUNC_APPEND: begin
        if (ecount < MaxEdges) begin
          efrom[ecount] = r.edge_from;
          eto[ecount] = r.edge_to;
          ewt[ecount] = r.edge_weight;
          ecount++;
        end
      end
      FUNC_COMPUTE: cost_q.push_back(tree_cost_of(r));
      default: ;
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (cost_q.size() == 0) begin
        report("unexpected result", out_res, '0);
      end else begin
        if (out_res !== cost_q[0]) report("result", out_res, cost_q[0]);
        void'(cost_q.pop_front());
      end
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("masked_kruskal_spanning_tree: mismatch");
      $finish;
    end
  end

  // send one request, honoring the idle rate, predicting once the block is idle;
  // start stays high on return so a following request can go back to back
  task automatic send(input in_req_t r);
    while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict(r);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (cost_q.size() != 0) @(negedge clk);
    repeat (HoldOff) @(negedge clk);
  endtask

  task automatic set_inf(input logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    inf_cost = v;
  endtask

  function automatic in_req_t mk(input func_t f, input int a, input int b, input int w,
                                 input int m, input int n);
    in_req_t r;
    r.func = f;
    r.edge_from = 4'(a);
    r.edge_to = 4'(b);
    r.edge_weight = 16'(w);
    r.vertex_mask = 16'(m);
    r.need_count = 5'(n);
    return r;
  endfunction

  function automatic in_req_t rand_req(input int p_compute, input int nv);
    in_req_t r;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    r = raw[$bits(in_req_t)-1:0];
    if ($urandom_range(99) < p_compute) r.func = FUNC_COMPUTE;
    else if ($urandom_range(49) == 0) r.func = FUNC_CLEAR;
    else if ($urandom_range(49) == 0) r.func = FUNC_NONE;
    else r.func = FUNC_APPEND;
    if ($urandom_range(3) != 0) begin
      r.edge_from = 4'($urandom_range(nv - 1));
      r.edge_to = 4'($urandom_range(nv - 1));
    end
    if ($urandom_range(2) == 0) r.edge_weight = 16'($urandom_range(15));
    if ($urandom_range(1) == 0) r.vertex_mask = 16'hFFFF;
    r.need_count = 5'($urandom_range(16));
    if ($urandom_range(2) == 0) r.need_count = 5'(31 - $urandom_range(14));
    return r;
  endfunction

  typedef struct {
    in_req_t  req;
    logic     has_res;
    out_res_t res;
  } row_t;

  initial begin
    row_t rows[$];
    int i, k, phase, nv;
    ecount = 0;
    inf_cost = 24'(InfResetVal);
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table: empty list, reset infeasible cost, extremes
    rows.push_back('{mk(FUNC_COMPUTE, 0, 0, 0, 16'hFFFF, 0), 1'b1, '{24'd0, 1'b1}});
    rows.push_back('{mk(FUNC_COMPUTE, 0, 0, 0, 16'hFFFF, 1), 1'b1, '{24'd0, 1'b1}});
    rows.push_back('{mk(FUNC_COMPUTE, 0, 0, 0, 16'hFFFF, 2), 1'b1, '{24'd1000000, 1'b0}});
    rows.push_back('{mk(FUNC_COMPUTE, 0, 0, 0, 0, 31), 1'b1, '{24'd1000000, 1'b0}});
    rows.push_back('{mk(FUNC_APPEND, 0, 15, 16'hFFFF, 0, 0), 1'b0, '0});
    rows.push_back('{mk(FUNC_COMPUTE, 0, 0, 0, 16'h8001, 2), 1'b1, '{24'd65535, 1'b1}});
    rows.push_back('{mk(FUNC_APPEND, 15, 0, 5, 0, 0), 1'b0, '0});
    rows.push_back('{mk(FUNC_APPEND, 3, 3, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(FUNC_APPEND, 1, 2, 7, 0, 0), 1'b0, '0});
    rows.push_back('{mk(FUNC_APPEND, 2, 1, 7, 0, 0), 1'b0, '0});
    rows.push_back('{mk(FUNC_APPEND, 0, 1, 7, 0, 0), 1'b0, '0});
    rows.push_back('{mk(FUNC_NONE, 4, 5, 1, 16'hFFFF, 16), 1'b0, '0});
    rows.push_back('{mk(FUNC_COMPUTE, 0, 0, 0, 16'hFFFF, 16), 1'b0, '0});
    rows.push_back('{mk(FUNC_COMPUTE, 0, 0, 0, 16'h8007, 4), 1'b0, '0});
    rows.push_back('{mk(FUNC_COMPUTE, 0, 0, 0, 16'h0006, 3), 1'b0, '0});
    rows.push_back('{mk(FUNC_CLEAR, 0, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk(FUNC_COMPUTE, 0, 0, 0, 16'hFFFF, 2), 1'b1, '{24'd1000000, 1'b0}});
    foreach (rows[i]) begin
      send(rows[i].req);
      if (rows[i].has_res) cost_q[cost_q.size()-1] = rows[i].res;
    end
    drain();

    // full list: 130 appends, the last ones dropped
    set_inf(24'hFFFFFF);
    for (i = 0; i < 130; i++)
      send(mk(FUNC_APPEND, $urandom_range(15), $urandom_range(15), $urandom, 0, 0));
    send(mk(FUNC_COMPUTE, 0, 0, 0, 16'hFFFF, 16));
    send(mk(FUNC_COMPUTE, 0, 0, 0, $urandom, $urandom_range(16)));
    send(mk(FUNC_CLEAR, 0, 0, 0, 0, 0));
    drain();

    // random phases with varied idling and infeasible costs
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: sender_idle = 0;
        1: sender_idle = 77;
        2: sender_idle = 0;
        default: sender_idle = 15;
      endcase
      case (phase)
        0: set_inf(24'd0);
        3: set_inf(24'(InfResetVal));
        default: set_inf(24'($urandom_range(24'hFFFFFF)));
      endcase
      nv = (phase % 2) ? 16 : 6;
      for (k = 0; k < 210; k++) begin
        if (ecount > 24 && $urandom_range(3) == 0)
          send(mk(FUNC_CLEAR, 0, 0, 0, 0, 0));
        else
          send(rand_req(12, nv));
      end
      drain();
    end

    if (errors == 0 && cost_q.size() == 0) begin
      $display("masked_kruskal_spanning_tree: match");
    end else begin
      $display("masked_kruskal_spanning_tree: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/mkst_pkg.sv
sv/mkst_ram.sv
sv/masked_kruskal_spanning_tree.sv
sv/mkst_checker.sv
tb/masked_kruskal_spanning_tree_tb.sv
